// ----- hw/rtl/gated_frame_ring_queue_assert.svh -----
// Assertion macros for the gated frame ring queue checker.
// No dependencies.
`ifndef GATED_FRAME_RING_QUEUE_ASSERT_SVH
`define GATED_FRAME_RING_QUEUE_ASSERT_SVH

`define GFRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gfrq assertion failed");

`define GFRQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gfrq assertion failed");

`define GFRQ_ASSERT_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("gfrq assertion failed");

`endif

// ----- hw/rtl/gfrq_pkg.sv -----
// Types and codes shared by the gated frame ring queue modules.
// No dependencies.
`default_nettype none
package gfrq_pkg;

   localparam logic [2:0] CMD_OFFER   = 3'd0;
   localparam logic [2:0] CMD_NEXT    = 3'd1;
   localparam logic [2:0] CMD_FLUSH   = 3'd2;
   localparam logic [2:0] CMD_CAPTURE = 3'd3;
   localparam logic [2:0] CMD_PROCESS = 3'd4;
   localparam logic [2:0] CMD_READ    = 3'd5;

   localparam logic [1:0] KIND_VERDICT = 2'd0;
   localparam logic [1:0] KIND_SAMPLE  = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;
   localparam logic [1:0] KIND_COUNTER = 2'd3;

   localparam logic [1:0] DISP_SENT    = 2'd0;
   localparam logic [1:0] DISP_INELIG  = 2'd1;
   localparam logic [1:0] DISP_GENCHG  = 2'd2;
   localparam logic [1:0] DISP_GATE    = 2'd3;

   localparam logic [2:0] CNT_CAPTURED   = 3'd0;
   localparam logic [2:0] CNT_PROCESSED  = 3'd1;
   localparam logic [2:0] CNT_ELIGIBLE   = 3'd2;
   localparam logic [2:0] CNT_INELIGIBLE = 3'd3;
   localparam logic [2:0] CNT_GENCHG     = 3'd4;
   localparam logic [2:0] CNT_GATE       = 3'd5;
   localparam logic [2:0] CNT_OVERFLOW   = 3'd6;
   localparam logic [2:0] CNT_SENT       = 3'd7;

   localparam int SLOT_MAX_W = 6;
   localparam int ADDR_MAX_W = 12;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [15:0] sample;
      logic               eligible_at_capture;
      logic [15:0]        capture_generation;
      logic [31:0]        capture_frame_index;
      logic [15:0]        clock_epoch;
      logic [15:0]        current_generation;
      logic               send_permitted;
      logic [2:0]         counter_select;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic               accepted;
      logic signed [15:0] out_sample;
      logic               frame_end;
      logic [31:0]        out_frame_index;
      logic [15:0]        out_epoch;
      logic [1:0]         disposition;
      logic [31:0]        counter_value;
   } rsp_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic                  accepted;
      logic [SLOT_MAX_W-1:0] slot;
      logic [31:0]           frame_index;
      logic [15:0]           epoch;
      logic [1:0]            disposition;
      logic [31:0]           counter_value;
   } job_type;

   typedef struct packed {
      logic                  en;
      logic [ADDR_MAX_W-1:0] addr;
      logic [15:0]           data;
   } wr_type;

endpackage
`default_nettype wire

// ----- hw/rtl/gfrq_job_fifo.sv -----
// Short job queue between the front and the back of the frame ring queue.
// Depends on gfrq_pkg.
`default_nettype none
module gfrq_job_fifo
   import gfrq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output job_type      head
);
   localparam int DEPTH = 4;

   job_type    entry_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   assign full  = (count_ff == 3'(DEPTH));
   assign empty = (count_ff == 3'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 2'd1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
      end
      count_in = count_ff + 3'(push && !full) - 3'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/gfrq_front.sv -----
// Front of the frame ring queue: takes requests, keeps counts, metadata and
// statistics, and queues jobs for the back. Depends on gfrq_pkg.
`default_nettype none
module gfrq_front
   import gfrq_pkg::*;
#(
   parameter int FRAME_SAMPLES   = 32,
   parameter int CAPACITY_FRAMES = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   output logic         job_push,
   output job_type      job_data,
   input  wire logic    job_full,
   input  wire logic    deq_done,
   output wr_type       wr
);
   localparam int POS_W  = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
   localparam int SLOT_W = $clog2(CAPACITY_FRAMES);

   typedef enum logic {ST_IDLE, ST_DEQ} state_type;

   state_type         state_ff, state_in;
   logic [31:0]       wc_ff, wc_in, rc_ff, rc_in, pend_ff, pend_in;
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in, rd_slot_ff, rd_slot_in, rd_adv;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              refused_ff, refused_in, elig_ff, elig_in, busy_ff, busy_in;
   logic [15:0]       gen_ff, gen_in;
   logic              permit_ff, permit_in;
   logic [31:0]       stat_ff [8];
   logic [16:0]       gate_mem [CAPACITY_FRAMES];
   logic [47:0]       meta_mem [CAPACITY_FRAMES];
   logic [16:0]       gate_rd_ff;
   logic [47:0]       meta_rd_ff;
   logic [SLOT_W-1:0] raddr;
   logic              meta_we;

   logic              accept, first, refused_eff, elig_eff, is_full;
   logic [31:0]       queued, drops, left;
   logic [SLOT_W:0]   adv_sum;
   logic              bump_en;
   logic [2:0]        bump_sel;
   logic [1:0]        disp;

   assign req_full = (state_ff != ST_IDLE) || job_full || busy_ff;
   assign accept   = req_push && !req_full;
   assign queued   = wc_ff - rc_ff;
   assign is_full  = (queued >= 32'(CAPACITY_FRAMES));
   assign drops    = (pend_ff < queued) ? pend_ff : queued;
   assign left     = queued - drops;
   assign first    = (pos_ff == '0);
   assign refused_eff = first ? is_full : refused_ff;
   assign elig_eff    = first ? req_data.eligible_at_capture : elig_ff;

   always_comb begin
      adv_sum = {1'b0, rd_slot_ff} + drops[SLOT_W:0];
      if (adv_sum >= (SLOT_W+1)'(CAPACITY_FRAMES)) begin
         adv_sum = adv_sum - (SLOT_W+1)'(CAPACITY_FRAMES);
      end
      rd_adv = adv_sum[SLOT_W-1:0];
   end

   always_comb begin
      priority if (gate_rd_ff[16] == 1'b0) begin
         disp = DISP_INELIG;
      end else if (gate_rd_ff[15:0] != gen_ff) begin
         disp = DISP_GENCHG;
      end else if (!permit_ff) begin
         disp = DISP_GATE;
      end else begin
         disp = DISP_SENT;
      end
   end

   always_comb begin
      state_in   = state_ff;
      wc_in      = wc_ff;
      rc_in      = rc_ff;
      pend_in    = pend_ff;
      wr_slot_in = wr_slot_ff;
      rd_slot_in = rd_slot_ff;
      pos_in     = pos_ff;
      refused_in = refused_ff;
      elig_in    = elig_ff;
      busy_in    = busy_ff && !deq_done;
      gen_in     = gen_ff;
      permit_in  = permit_ff;
      raddr      = rd_slot_ff;
      meta_we    = 1'b0;
      bump_en    = 1'b0;
      bump_sel   = CNT_CAPTURED;
      job_push   = 1'b0;
      job_data   = '0;
      wr         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  CMD_OFFER: begin
                     if (first) begin
                        job_push          = 1'b1;
                        job_data.kind     = KIND_VERDICT;
                        job_data.accepted = !is_full;
                        refused_in        = is_full;
                        elig_in           = req_data.eligible_at_capture;
                        if (is_full) begin
                           if (pend_ff != '1) begin
                              pend_in = pend_ff + 32'd1;
                           end
                           bump_en  = 1'b1;
                           bump_sel = CNT_OVERFLOW;
                        end else begin
                           meta_we = 1'b1;
                        end
                     end
                     if (!refused_eff) begin
                        wr.en   = 1'b1;
                        wr.addr = ADDR_MAX_W'(32'(wr_slot_ff) * FRAME_SAMPLES + 32'(pos_ff));
                        wr.data = req_data.sample;
                        if (pos_ff == POS_W'(FRAME_SAMPLES - 1)) begin
                           wc_in = wc_ff + 32'd1;
                           wr_slot_in = (wr_slot_ff == SLOT_W'(CAPACITY_FRAMES - 1)) ?
                                        '0 : wr_slot_ff + 1'b1;
                           if (elig_eff) begin
                              bump_en  = 1'b1;
                              bump_sel = CNT_ELIGIBLE;
                           end
                        end
                     end
                     pos_in = (pos_ff == POS_W'(FRAME_SAMPLES - 1)) ? '0 : pos_ff + 1'b1;
                  end
                  CMD_NEXT: begin
                     rc_in      = rc_ff + drops;
                     rd_slot_in = rd_adv;
                     pend_in    = '0;
                     raddr      = rd_adv;
                     gen_in     = req_data.current_generation;
                     permit_in  = req_data.send_permitted;
                     if (left == '0) begin
                        job_push      = 1'b1;
                        job_data.kind = KIND_EMPTY;
                     end else begin
                        state_in = ST_DEQ;
                     end
                  end
                  CMD_FLUSH: begin
                     rc_in      = wc_ff;
                     rd_slot_in = wr_slot_ff;
                  end
                  CMD_CAPTURE: begin
                     bump_en  = 1'b1;
                     bump_sel = CNT_CAPTURED;
                  end
                  CMD_PROCESS: begin
                     bump_en  = 1'b1;
                     bump_sel = CNT_PROCESSED;
                  end
                  CMD_READ: begin
                     job_push               = 1'b1;
                     job_data.kind          = KIND_COUNTER;
                     job_data.counter_value = stat_ff[req_data.counter_select];
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DEQ: begin
            if (!job_full) begin
               job_push             = 1'b1;
               job_data.kind        = KIND_SAMPLE;
               job_data.slot        = SLOT_MAX_W'(rd_slot_ff);
               job_data.frame_index = meta_rd_ff[47:16];
               job_data.epoch       = meta_rd_ff[15:0];
               job_data.disposition = disp;
               bump_en  = 1'b1;
               unique case (disp)
                  DISP_INELIG: bump_sel = CNT_INELIGIBLE;
                  DISP_GENCHG: bump_sel = CNT_GENCHG;
                  DISP_GATE:   bump_sel = CNT_GATE;
                  default:     bump_sel = CNT_SENT;
               endcase
               rc_in      = rc_ff + 32'd1;
               rd_slot_in = (rd_slot_ff == SLOT_W'(CAPACITY_FRAMES - 1)) ?
                            '0 : rd_slot_ff + 1'b1;
               busy_in    = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wc_ff      <= '0;
         rc_ff      <= '0;
         pend_ff    <= '0;
         wr_slot_ff <= '0;
         rd_slot_ff <= '0;
         pos_ff     <= '0;
         refused_ff <= 1'b0;
         elig_ff    <= 1'b0;
         busy_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            stat_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         wc_ff      <= wc_in;
         rc_ff      <= rc_in;
         pend_ff    <= pend_in;
         wr_slot_ff <= wr_slot_in;
         rd_slot_ff <= rd_slot_in;
         pos_ff     <= pos_in;
         refused_ff <= refused_in;
         elig_ff    <= elig_in;
         busy_ff    <= busy_in;
         if (bump_en) begin
            stat_ff[bump_sel] <= stat_ff[bump_sel] + 32'd1;
         end
      end
      gen_ff    <= gen_in;
      permit_ff <= permit_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         gate_mem[wr_slot_ff] <= {req_data.eligible_at_capture, req_data.capture_generation};
         meta_mem[wr_slot_ff] <= {req_data.capture_frame_index, req_data.clock_epoch};
      end
      gate_rd_ff <= gate_mem[raddr];
      meta_rd_ff <= meta_mem[raddr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/gfrq_back.sv -----
// Back of the frame ring queue: holds the sample store, runs jobs and
// drives the result register. Depends on gfrq_pkg.
`default_nettype none
module gfrq_back
   import gfrq_pkg::*;
#(
   parameter int FRAME_SAMPLES   = 32,
   parameter int CAPACITY_FRAMES = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire wr_type  wr,
   input  wire logic    job_empty,
   input  wire job_type job_head,
   output logic         job_pop,
   output logic         deq_done,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);
   localparam int POS_W  = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
   localparam int DEPTH  = FRAME_SAMPLES * CAPACITY_FRAMES;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} state_type;

   state_type        state_ff;
   logic [15:0]      store [DEPTH];
   logic [15:0]      rd_data_ff;
   job_type          job_ff;
   logic [POS_W-1:0] k_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             valid_ff, valid_in;
   logic             out_free, last;
   logic [ADDR_W-1:0] raddr;

   assign out_free  = !valid_ff || rsp_pop;
   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;
   assign last      = (k_ff == POS_W'(FRAME_SAMPLES - 1));
   assign raddr     = ADDR_W'(32'(job_ff.slot) * FRAME_SAMPLES + 32'(k_ff));
   assign job_pop   = (state_ff == ST_IDLE) && !job_empty && out_free;
   assign deq_done  = (state_ff == ST_EMIT) && out_free && last;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store[wr.addr[ADDR_W-1:0]] <= wr.data;
      end
      rd_data_ff <= store[raddr];
   end

   always_comb begin
      valid_in = valid_ff && !rsp_pop;
      rsp_in   = rsp_ff;
      if (job_pop && (job_head.kind != KIND_SAMPLE)) begin
         valid_in             = 1'b1;
         rsp_in               = '0;
         rsp_in.result_kind   = job_head.kind;
         rsp_in.accepted      = job_head.accepted;
         rsp_in.counter_value = job_head.counter_value;
      end else if ((state_ff == ST_EMIT) && out_free) begin
         valid_in               = 1'b1;
         rsp_in                 = '0;
         rsp_in.result_kind     = KIND_SAMPLE;
         rsp_in.out_sample      = rd_data_ff;
         rsp_in.frame_end       = last;
         rsp_in.out_frame_index = job_ff.frame_index;
         rsp_in.out_epoch       = job_ff.epoch;
         rsp_in.disposition     = job_ff.disposition;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_pop && (job_head.kind == KIND_SAMPLE)) begin
                  job_ff   <= job_head;
                  k_ff     <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (out_free) begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= last ? ST_IDLE : ST_READ;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/gated_frame_ring_queue.sv -----
// Gated frame ring queue top level. A verdict, empty or counter result passes the job
// queue, then the result register; a dequeued frame passes the front's dequeue state,
// then the job queue, then each sample the back's store read and the result register.
// One request per cycle while req_full is low; a next-frame request holds the front
// until its job is queued; requests wait until the frame's last sample is registered.
// Reset: synchronous; clears counts, statistics and queues; stores hold until written.
`default_nettype none
module gated_frame_ring_queue
   import gfrq_pkg::*;
#(
   parameter int FRAME_SAMPLES   = 32,
   parameter int CAPACITY_FRAMES = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);
   logic    job_push, job_full, job_pop, job_empty, deq_done;
   job_type job_in, job_head;
   wr_type  wr;

   gfrq_front #(
      .FRAME_SAMPLES(FRAME_SAMPLES),
      .CAPACITY_FRAMES(CAPACITY_FRAMES)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .job_push(job_push), .job_data(job_in), .job_full(job_full),
      .deq_done(deq_done), .wr(wr)
   );

   gfrq_job_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(job_push), .push_job(job_in), .full(job_full),
      .pop(job_pop), .empty(job_empty), .head(job_head)
   );

   gfrq_back #(
      .FRAME_SAMPLES(FRAME_SAMPLES),
      .CAPACITY_FRAMES(CAPACITY_FRAMES)
   ) u_back (
      .clock(clock), .reset(reset), .wr(wr),
      .job_empty(job_empty), .job_head(job_head), .job_pop(job_pop),
      .deq_done(deq_done),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

// ----- hw/rtl/gfrq_checker.sv -----
// Port checker for the gated frame ring queue, bound to the top level.
// Depends on gfrq_pkg and gated_frame_ring_queue_assert.svh.
`default_nettype none
`include "gated_frame_ring_queue_assert.svh"
module gfrq_checker
   import gfrq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_full,
   input wire logic    rsp_empty,
   input wire logic    rsp_pop,
   input wire rsp_type rsp_data
);
   logic is_sample, is_other, sample_clean, other_clean;

   assign is_sample    = !rsp_empty && (rsp_data.result_kind == KIND_SAMPLE);
   assign is_other     = !rsp_empty && (rsp_data.result_kind != KIND_SAMPLE);
   assign sample_clean = (rsp_data.accepted == 1'b0) && (rsp_data.counter_value == 32'd0);
   assign other_clean  = (rsp_data.out_sample == 16'sd0) && (rsp_data.frame_end == 1'b0) &&
                         (rsp_data.disposition == DISP_SENT);

   `GFRQ_ASSERT_RESET(a_reset_empty, clock, reset, rsp_empty)
   `GFRQ_ASSERT_RESET(a_reset_ready, clock, reset, !req_full)
   `GFRQ_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))
   `GFRQ_ASSERT_NOW(a_sample_clean, clock, reset, is_sample, sample_clean)
   `GFRQ_ASSERT_NOW(a_other_clean, clock, reset, is_other, other_clean)
endmodule

bind gated_frame_ring_queue gfrq_checker u_checker (
   .clock(clock), .reset(reset), .req_full(req_full),
   .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
);
`default_nettype wire
